FILE: design/aels_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aels_pkg
// Shared constants, codes and controller/datapath interface types for the
// absorber energy loss stepper.
// ----------------------------------------------------------------------------
package aels_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int N_W         = ADDR_W + 1;

  localparam int VAL_W       = 32;
  localparam int MASS_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int IDX_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int MASS_FRAC   = 8;

  localparam int E_W         = VAL_W + 1;          // running energy, signed
  localparam int MAG_W       = E_W + MASS_FRAC;    // |e| * 256
  localparam int EPA_W       = MAG_W + 1;          // energy per amu, signed
  localparam int MD_W        = EPA_W;              // |epa - lo|
  localparam int PROD_W      = MD_W + VAL_W;       // |diff| * |dd|
  localparam int REM_W       = VAL_W + 1;
  localparam int TERM_SHIFT  = 40;
  localparam int TERM_W      = TERM_SHIFT + 1;
  localparam int WIDE_W      = TERM_W + 2;
  localparam int SLICE_W     = FRAC_BITS + 1;
  localparam int PROD_S_W    = VAL_W + SLICE_W + 1;
  localparam int LOSS_W      = PROD_S_W - FRAC_BITS;
  localparam int RAM_W       = 2 * VAL_W;

  localparam int EPA_STEPS   = MAG_W;
  localparam int QDIV_STEPS  = PROD_W;
  localparam int MUL_STEPS   = VAL_W;
  localparam int STEP_W      = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_RESIDUAL = 2'd1,
    FUNC_INITIAL  = 2'd2,
    FUNC_DEDX     = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  localparam logic [MASS_W-1:0]  MASS_RESET  = 16'd256;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_WRITE,
    OP_EPA_LOAD,
    OP_DIV_STEP,
    OP_EPA_SET,
    OP_CAP_LO,
    OP_CAP_HI,
    OP_PREP,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_QDIV_LOAD,
    OP_DEDX_TERM,
    OP_DEDX_LO,
    OP_LOSS,
    OP_APPLY,
    OP_SLICE_NEXT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    func_t          func;
    logic           epa_lt;
    logic           epa_gt;
    logic           w_pos;
    logic           slice_zero;
    logic           slice_last;
    logic [N_W-1:0] n;
  } dp_stat_t;

  // Saturate to signed VAL_W; result is {overflow, value}.
  function automatic logic [VAL_W:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    lo_lim = -(64'sd1 <<< (VAL_W - 1));
    if (v > hi_lim) begin
      sat_val = {1'b1, hi_lim[VAL_W-1:0]};
    end else if (v < lo_lim) begin
      sat_val = {1'b1, lo_lim[VAL_W-1:0]};
    end else begin
      sat_val = {1'b0, v[VAL_W-1:0]};
    end
  endfunction

endpackage

FILE: design/aels_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aels_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module aels_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/aels_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aels_ctrl
// Sequencer: table search, serial multiply/divide counts, slice loop.
// ----------------------------------------------------------------------------
module aels_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              result_valid,
  output aels_pkg::dp_cmd_t cmd,
  input  aels_pkg::dp_stat_t stat
);
  import aels_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_WRITE, S_SLICE, S_EPA_LOAD, S_DIV, S_EPA_SET,
    S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_SCAN_RD, S_SCAN_CHK,
    S_SEG_LO, S_SEG_HI, S_CAP_HI, S_PREP, S_WCHK, S_MUL_LOAD, S_MUL,
    S_QDIV_LOAD, S_TERM, S_DEDX_LO, S_LOSS, S_APPLY, S_SLICE_NEXT, S_FINISH
  } state_t;

  state_t            state;
  state_t            ret;
  logic [STEP_W-1:0] cnt;
  logic [ADDR_W-1:0] seg;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] last_entry;
  logic [ADDR_W-1:0] last_scan;

  assign last_entry = ADDR_W'(stat.n - N_W'(1));
  assign last_scan  = ADDR_W'(stat.n - N_W'(2));

  always_comb begin
    cmd.op      = OP_IDLE;
    cmd.rd_addr = '0;
    case (state)
      S_IDLE:       cmd.op = start ? OP_LATCH : OP_IDLE;
      S_WRITE:      cmd.op = OP_WRITE;
      S_EPA_LOAD:   cmd.op = OP_EPA_LOAD;
      S_DIV:        cmd.op = OP_DIV_STEP;
      S_EPA_SET:    cmd.op = OP_EPA_SET;
      S_RD_FIRST:   cmd.rd_addr = '0;
      S_CHK_FIRST:  cmd.rd_addr = last_entry;
      S_SCAN_RD:    cmd.rd_addr = idx;
      S_SEG_LO:     cmd.rd_addr = seg;
      S_SEG_HI: begin
        cmd.op      = OP_CAP_LO;
        cmd.rd_addr = seg + ADDR_W'(1);
      end
      S_CAP_HI:     cmd.op = OP_CAP_HI;
      S_PREP:       cmd.op = OP_PREP;
      S_MUL_LOAD:   cmd.op = OP_MUL_LOAD;
      S_MUL:        cmd.op = OP_MUL_STEP;
      S_QDIV_LOAD:  cmd.op = OP_QDIV_LOAD;
      S_TERM:       cmd.op = OP_DEDX_TERM;
      S_DEDX_LO:    cmd.op = OP_DEDX_LO;
      S_LOSS:       cmd.op = OP_LOSS;
      S_APPLY:      cmd.op = OP_APPLY;
      S_SLICE_NEXT: cmd.op = OP_SLICE_NEXT;
      S_FINISH:     cmd.op = OP_OUT;
      default:      cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      cnt          <= '0;
      seg          <= '0;
      idx          <= '0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (stat.func)
            FUNC_LOAD: state <= S_WRITE;
            FUNC_DEDX: state <= S_EPA_LOAD;
            default:   state <= S_SLICE;
          endcase
        end
        S_WRITE: state <= S_FINISH;
        S_SLICE: state <= stat.slice_zero ? S_SLICE_NEXT : S_EPA_LOAD;
        S_EPA_LOAD: begin
          cnt   <= STEP_W'(EPA_STEPS);
          ret   <= S_EPA_SET;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) begin
            state <= ret;
          end
        end
        S_EPA_SET:  state <= S_RD_FIRST;
        S_RD_FIRST: state <= S_CHK_FIRST;
        S_CHK_FIRST: begin
          if (stat.epa_lt) begin
            seg   <= '0;
            state <= S_SEG_LO;
          end else begin
            state <= S_CHK_LAST;
          end
        end
        S_CHK_LAST: begin
          if (stat.epa_gt) begin
            seg   <= last_scan;
            state <= S_SEG_LO;
          end else begin
            seg   <= '0;
            idx   <= ADDR_W'(1);
            state <= (last_scan == '0) ? S_SEG_LO : S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (stat.epa_lt) begin
            state <= S_SEG_LO;
          end else begin
            seg <= idx;
            idx <= idx + ADDR_W'(1);
            state <= (idx == last_scan) ? S_SEG_LO : S_SCAN_RD;
          end
        end
        S_SEG_LO: state <= S_SEG_HI;
        S_SEG_HI: state <= S_CAP_HI;
        S_CAP_HI: state <= S_PREP;
        S_PREP:   state <= S_WCHK;
        S_WCHK:   state <= stat.w_pos ? S_MUL_LOAD : S_DEDX_LO;
        S_MUL_LOAD: begin
          cnt   <= STEP_W'(MUL_STEPS);
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) begin
            state <= S_QDIV_LOAD;
          end
        end
        S_QDIV_LOAD: begin
          cnt   <= STEP_W'(QDIV_STEPS);
          ret   <= S_TERM;
          state <= S_DIV;
        end
        S_TERM, S_DEDX_LO: begin
          state <= (stat.func == FUNC_DEDX) ? S_FINISH : S_LOSS;
        end
        S_LOSS:       state <= S_APPLY;
        S_APPLY:      state <= S_SLICE_NEXT;
        S_SLICE_NEXT: state <= stat.slice_last ? S_FINISH : S_SLICE;
        S_FINISH: begin
          busy         <= 1'b0;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/aels_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aels_dp
// Datapath: config registers, table RAM, shared bit-serial divider,
// bit-serial multiplier, interpolation and slice energy update.
// ----------------------------------------------------------------------------
module aels_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aels_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aels_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          func,
  input  logic [aels_pkg::IDX_W-1:0]          entry_index,
  input  logic [aels_pkg::VAL_W-1:0]          energy_value,
  input  logic [aels_pkg::VAL_W-1:0]          dedx_value,
  input  logic [aels_pkg::VAL_W-1:0]          thickness,
  input  aels_pkg::dp_cmd_t                   cmd,
  output aels_pkg::dp_stat_t                  stat,
  output logic signed [aels_pkg::VAL_W-1:0]   result_value,
  output logic [aels_pkg::STATUS_W-1:0]       status
);
  import aels_pkg::*;

  localparam logic [VAL_W-1:0]  ONE        = VAL_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] TERM_LIMIT = PROD_W'(1) << TERM_SHIFT;

  logic [MASS_W-1:0]        mass;
  logic [COUNT_W-1:0]       count;
  func_t                    func_r;
  logic                     idx_ok;
  logic [ADDR_W-1:0]        waddr;
  logic [VAL_W-1:0]         ev_r;
  logic [VAL_W-1:0]         dv_r;
  logic [VAL_W-1:0]         t_r;
  logic signed [E_W-1:0]    e_r;
  logic                     flag;
  logic signed [EPA_W-1:0]  epa;
  logic [REM_W-1:0]         rem;
  logic [PROD_W-1:0]        dq;
  logic [VAL_W-1:0]         divisor;
  logic [VAL_W-1:0]         lo, hi, dlo, dhi;
  logic signed [VAL_W:0]    w;
  logic                     diff_neg, dd_neg;
  logic [MD_W-1:0]          md;
  logic [VAL_W-1:0]         mdd;
  logic [PROD_W-1:0]        acc;
  logic [VAL_W-1:0]         mq;
  logic signed [VAL_W-1:0]  de;
  logic signed [PROD_S_W-1:0] p;

  logic [RAM_W-1:0]         rd_data;
  logic [VAL_W-1:0]         rd_e, rd_d;
  logic signed [EPA_W-1:0]  rd_e_s;
  logic [SLICE_W-1:0]       slice;
  logic [E_W-1:0]           e_mag;
  logic [REM_W-1:0]         rem_sh;
  logic                     q_bit;
  logic [TERM_W-1:0]        term;
  logic signed [WIDE_W-1:0] dlo_s, term_s, wide;
  logic [VAL_W:0]           sat_d, sat_e;
  logic [PROD_S_W-1:0]      p_mag;
  logic [LOSS_W-1:0]        loss;
  logic signed [63:0]       sloss, e_next64;
  logic signed [EPA_W:0]    diff;
  logic signed [VAL_W:0]    dd;

  aels_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE && idx_ok),
    .waddr (waddr),
    .wdata ({ev_r, dv_r}),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  assign rd_e   = rd_data[RAM_W-1:VAL_W];
  assign rd_d   = rd_data[VAL_W-1:0];
  assign rd_e_s = $signed({{(EPA_W-VAL_W){1'b0}}, rd_e});

  assign slice  = (t_r < ONE) ? SLICE_W'(t_r) : SLICE_W'(ONE);
  assign e_mag  = e_r[E_W-1] ? E_W'(-e_r) : E_W'(e_r);

  // one restoring division step
  assign rem_sh = {rem[REM_W-2:0], dq[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor});

  assign term   = (dq > TERM_LIMIT) ? TERM_W'(TERM_LIMIT) : dq[TERM_W-1:0];
  assign dlo_s  = $signed({{(WIDE_W-VAL_W){1'b0}}, dlo});
  assign term_s = $signed({{(WIDE_W-TERM_W){1'b0}}, term});
  assign wide   = (cmd.op == OP_DEDX_LO) ? dlo_s :
                  ((diff_neg != dd_neg) ? dlo_s - term_s : dlo_s + term_s);
  assign sat_d  = sat_val(64'(wide));

  assign p_mag    = p[PROD_S_W-1] ? PROD_S_W'(-p) : PROD_S_W'(p);
  assign loss     = LOSS_W'(p_mag >> FRAC_BITS);
  assign sloss    = p[PROD_S_W-1] ? -$signed(64'(loss)) : $signed(64'(loss));
  assign e_next64 = (func_r == FUNC_RESIDUAL) ? 64'(e_r) - sloss : 64'(e_r) + sloss;
  assign sat_e    = sat_val(e_next64);

  assign diff = $signed({epa[EPA_W-1], epa}) - $signed({{(EPA_W+1-VAL_W){1'b0}}, lo});
  assign dd   = $signed({1'b0, dhi}) - $signed({1'b0, dlo});

  always_comb begin
    stat.func       = func_r;
    stat.epa_lt     = epa < rd_e_s;
    stat.epa_gt     = epa > rd_e_s;
    stat.w_pos      = !w[VAL_W] && (w != '0);
    stat.slice_zero = (t_r == '0);
    stat.slice_last = (t_r <= ONE);
    if (32'(count) < 32'd2) begin
      stat.n = N_W'(2);
    end else if (32'(count) > 32'(TABLE_DEPTH)) begin
      stat.n = N_W'(TABLE_DEPTH);
    end else begin
      stat.n = N_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mass  <= MASS_RESET;
      count <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASS:  mass  <= cfg_data[MASS_W-1:0];
        CFG_COUNT: count <= cfg_data[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        func_r <= func_t'(func);
        idx_ok <= (32'(entry_index) < 32'(TABLE_DEPTH));
        waddr  <= ADDR_W'(entry_index);
        ev_r   <= energy_value;
        dv_r   <= dedx_value;
        t_r    <= thickness;
        if (func_t'(func) == FUNC_DEDX || !energy_value[VAL_W-1]) begin
          e_r  <= $signed({1'b0, energy_value});
          flag <= 1'b0;
        end else begin
          e_r  <= $signed({2'b00, {(VAL_W-1){1'b1}}});
          flag <= 1'b1;
        end
      end
      OP_EPA_LOAD: begin
        dq      <= {e_mag, {MASS_FRAC{1'b0}}, {(PROD_W-MAG_W){1'b0}}};
        rem     <= '0;
        divisor <= (mass == '0) ? VAL_W'(1) : VAL_W'(mass);
      end
      OP_DIV_STEP: begin
        rem <= q_bit ? rem_sh - {1'b0, divisor} : rem_sh;
        dq  <= {dq[PROD_W-2:0], q_bit};
      end
      OP_EPA_SET: begin
        epa <= e_r[E_W-1] ? -$signed({1'b0, dq[MAG_W-1:0]})
                          :  $signed({1'b0, dq[MAG_W-1:0]});
      end
      OP_CAP_LO: begin
        lo  <= rd_e;
        dlo <= rd_d;
      end
      OP_CAP_HI: begin
        hi  <= rd_e;
        dhi <= rd_d;
      end
      OP_PREP: begin
        w        <= $signed({1'b0, hi}) - $signed({1'b0, lo});
        diff_neg <= diff[EPA_W];
        md       <= diff[EPA_W] ? MD_W'(-diff) : MD_W'(diff);
        dd_neg   <= dd[VAL_W];
        mdd      <= dd[VAL_W] ? VAL_W'(-dd) : VAL_W'(dd);
      end
      OP_MUL_LOAD: begin
        acc <= '0;
        mq  <= mdd;
      end
      OP_MUL_STEP: begin
        acc <= {acc[PROD_W-2:0], 1'b0} + (mq[VAL_W-1] ? PROD_W'(md) : '0);
        mq  <= {mq[VAL_W-2:0], 1'b0};
      end
      OP_QDIV_LOAD: begin
        dq      <= acc;
        rem     <= '0;
        divisor <= w[VAL_W-1:0];
      end
      OP_DEDX_TERM, OP_DEDX_LO: begin
        de   <= $signed(sat_d[VAL_W-1:0]);
        flag <= flag | sat_d[VAL_W];
      end
      OP_LOSS: begin
        p <= de * $signed({1'b0, slice});
      end
      OP_APPLY: begin
        e_r  <= $signed({sat_e[VAL_W-1], sat_e[VAL_W-1:0]});
        flag <= flag | sat_e[VAL_W];
      end
      OP_SLICE_NEXT: begin
        t_r <= t_r - ONE;
      end
      OP_OUT: begin
        case (func_r)
          FUNC_LOAD: begin
            result_value <= '0;
            status       <= idx_ok ? ST_OK : ST_BAD_INDEX;
          end
          FUNC_DEDX: begin
            result_value <= de;
            status       <= flag ? ST_SAT : ST_OK;
          end
          default: begin
            result_value <= e_r[VAL_W-1:0];
            status       <= flag ? ST_SAT : ST_OK;
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

FILE: design/absorber_energy_loss_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absorber_energy_loss_stepper_core
// Stopping-power table with dE/dx interpolation and slice-wise energy loss
// (residual) or gain (initial) through an absorber.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with result_valid, and must be captured
// then since the receiver cannot stall the block. busy drops in the same
// cycle as result_valid, so a new item may be issued right there. A table
// load passes through the dispatch, write and finish states. A dE/dx query
// runs an energy/mass division, a segment search over the table entries in
// use, and, when the segment width is positive, a bit-serial multiply and a
// bit-serial interpolation divide; the two divisions share one divider.
// Residual and initial energy queries repeat that per 1.0 mg/cm2 slice of
// the thickness. Configuration (index 0 particle mass, index 1 entry count)
// is always ready and is to be written only while busy is low. Table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module absorber_energy_loss_stepper_core (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func,
  input  logic [aels_pkg::IDX_W-1:0]          entry_index,
  input  logic [aels_pkg::VAL_W-1:0]          energy_value,
  input  logic [aels_pkg::VAL_W-1:0]          dedx_value,
  input  logic [aels_pkg::VAL_W-1:0]          thickness,
  // result strobe
  output logic                                result_valid,
  output logic signed [aels_pkg::VAL_W-1:0]   result_value,
  output logic [aels_pkg::STATUS_W-1:0]       status,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aels_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aels_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aels_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  aels_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd),
    .stat         (stat)
  );

  aels_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .entry_index  (entry_index),
    .energy_value (energy_value),
    .dedx_value   (dedx_value),
    .thickness    (thickness),
    .cmd          (cmd),
    .stat         (stat),
    .result_value (result_value),
    .status       (status)
  );

endmodule

FILE: design/aels_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aels_checker
// Port-level checks on the item/result sequencing of the core.
// ----------------------------------------------------------------------------
module aels_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              result_valid,
  input logic [aels_pkg::VAL_W-1:0]        result_value,
  input logic [aels_pkg::STATUS_W-1:0]     status
);
  import aels_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_done_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid)
    else $error("busy dropped without a result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_SAT || status == ST_BAD_INDEX))
    else $error("undefined status code");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_BAD_INDEX) |-> (result_value == '0))
    else $error("rejected load returned a nonzero value");

endmodule

bind absorber_energy_loss_stepper_core aels_checker u_aels_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result_value (result_value),
  .status       (status)
);
